### hdl/safs_pkg.sv
// ----------------------------------------------------------------------------
// Sprite animation frame select - shared package
// Widths, register codes and playback modes used by the frame select pipeline.
// ----------------------------------------------------------------------------
package safs_pkg;

	localparam int INDEX_BITS     = 12;
	localparam int TIME_BITS      = 32;
	localparam int TIME_FRAC_BITS = 16;
	localparam int RATE_BITS      = 16;
	localparam int RATE_FRAC_BITS = 8;
	localparam int CFG_IDX_BITS   = 2;
	localparam int CFG_DATA_BITS  = 16;

	localparam int PROD_BITS  = TIME_BITS + RATE_BITS;
	localparam int FRAC_SHIFT = TIME_FRAC_BITS + RATE_FRAC_BITS;
	localparam int FRAME_BITS = PROD_BITS - FRAC_SHIFT;
	localparam int CNT_BITS   = INDEX_BITS + 1;

	localparam logic [RATE_BITS-1:0] RATE_ONE = RATE_BITS'(1) << RATE_FRAC_BITS;

	typedef enum logic [1:0] {
		MODE_ONCE     = 2'd0,
		MODE_LOOP     = 2'd1,
		MODE_PINGPONG = 2'd2
	} mode_t;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_START_INDEX   = 2'd0,
		REG_END_INDEX     = 2'd1,
		REG_FRAME_RATE    = 2'd2,
		REG_PLAYBACK_MODE = 2'd3
	} cfg_reg_t;

endpackage

### hdl/safs_div_pipe.sv
// ----------------------------------------------------------------------------
// Sprite animation frame select - pipelined divider
// Restoring division of the frame count, one quotient bit per stage. Gives the
// remainder and the parity of the quotient; the clamp offset rides alongside.
// ----------------------------------------------------------------------------
module safs_div_pipe
	import safs_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [FRAME_BITS-1:0] in_frames,
	input  logic [INDEX_BITS-1:0] in_clamp,
	input  logic [CNT_BITS-1:0]   divisor,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [CNT_BITS-1:0]   out_rem,
	output logic                  out_lap_odd,
	output logic [INDEX_BITS-1:0] out_clamp
);

	localparam int LAST = FRAME_BITS - 1;

	logic [FRAME_BITS-1:0] vld_s;
	logic [FRAME_BITS-1:0] load;
	logic [FRAME_BITS-1:0] qbit_s;
	logic [CNT_BITS-1:0]   rem_s   [FRAME_BITS];
	logic [FRAME_BITS-1:0] dvd_s   [FRAME_BITS];
	logic [INDEX_BITS-1:0] clamp_s [FRAME_BITS];

	// stall chain: a stage loads when empty or when the next one moves
	always_comb begin
		load[LAST] = !vld_s[LAST] || out_ready;
		for (int k = LAST - 1; k >= 0; k--) begin
			load[k] = !vld_s[k] || load[k+1];
		end
	end

	genvar g;
	generate
		for (g = 0; g < FRAME_BITS; g++) begin : g_stage
			logic                  prev_vld;
			logic [CNT_BITS-1:0]   prev_rem;
			logic [FRAME_BITS-1:0] prev_dvd;
			logic [INDEX_BITS-1:0] prev_clamp;
			logic [CNT_BITS:0]     trial;
			logic                  ge;
			logic [CNT_BITS:0]     diff;

			if (g == 0) begin : g_first
				assign prev_vld   = in_valid;
				assign prev_rem   = '0;
				assign prev_dvd   = in_frames;
				assign prev_clamp = in_clamp;
			end else begin : g_next
				assign prev_vld   = vld_s[g-1];
				assign prev_rem   = rem_s[g-1];
				assign prev_dvd   = dvd_s[g-1];
				assign prev_clamp = clamp_s[g-1];
			end

			assign trial = {prev_rem, prev_dvd[FRAME_BITS-1]};
			assign ge    = trial >= {1'b0, divisor};
			assign diff  = trial - {1'b0, divisor};

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_s[g] <= 1'b0;
				end else if (load[g]) begin
					vld_s[g] <= prev_vld;
				end
			end

			always_ff @(posedge clk) begin
				if (load[g] && prev_vld) begin
					rem_s[g]   <= ge ? diff[CNT_BITS-1:0] : trial[CNT_BITS-1:0];
					qbit_s[g]  <= ge;
					dvd_s[g]   <= {prev_dvd[FRAME_BITS-2:0], 1'b0};
					clamp_s[g] <= prev_clamp;
				end
			end
		end
	endgenerate

	assign in_ready    = load[0];
	assign out_valid   = vld_s[LAST];
	assign out_rem     = rem_s[LAST];
	assign out_lap_odd = qbit_s[LAST];
	assign out_clamp   = clamp_s[LAST];

endmodule

### hdl/sprite_anim_frame_select.sv
// ----------------------------------------------------------------------------
// Sprite animation frame select - top level
// Maps an elapsed time to a sprite sheet index in once, loop or ping-pong mode.
// ----------------------------------------------------------------------------
// One item per clock cycle is sustained while out_ready stays high. From input
// accept to result, the time by rate product is registered, then the frame
// count and the clamp, then each stage of the pipelined restoring divider, and
// last the index. The divider depth sets the latency. Each stage only waits on
// the one after it, so gaps close up and input is taken while a result is held.
// Registers are written through the cfg port, which is always ready; write
// them only while no items are in flight.
// ----------------------------------------------------------------------------
module sprite_anim_frame_select
	import safs_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [TIME_BITS-1:0]     elapsed_time,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [INDEX_BITS-1:0]    sprite_index,
	output logic                     range_error
);

	logic [INDEX_BITS-1:0] start_index_q;
	logic [INDEX_BITS-1:0] end_index_q;
	logic [RATE_BITS-1:0]  frame_rate_q;
	logic [1:0]            playback_mode_q;

	logic [INDEX_BITS-1:0] span;
	logic [CNT_BITS-1:0]   count;
	logic [CNT_BITS-1:0]   divisor;
	logic                  bad_range;

	logic                  vld_s1, vld_s2;
	logic                  load_s1, load_s2;
	logic [PROD_BITS-1:0]  prod_s1;
	logic [FRAME_BITS-1:0] frames_s2;
	logic [INDEX_BITS-1:0] clamp_s2;
	logic [FRAME_BITS-1:0] frames_w;

	logic                  div_in_ready;
	logic                  div_out_valid;
	logic                  div_out_ready;
	logic [CNT_BITS-1:0]   div_rem;
	logic                  div_lap_odd;
	logic [INDEX_BITS-1:0] div_clamp;

	logic [INDEX_BITS-1:0] offset;
	logic                  out_valid_q;
	logic [INDEX_BITS-1:0] sprite_index_q;
	logic                  range_error_q;

	// configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_index_q   <= '0;
			end_index_q     <= '0;
			frame_rate_q    <= RATE_ONE;
			playback_mode_q <= MODE_ONCE;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_START_INDEX:   start_index_q   <= cfg_data[INDEX_BITS-1:0];
				REG_END_INDEX:     end_index_q     <= cfg_data[INDEX_BITS-1:0];
				REG_FRAME_RATE:    frame_rate_q    <= cfg_data[RATE_BITS-1:0];
				REG_PLAYBACK_MODE: playback_mode_q <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	assign bad_range = end_index_q < start_index_q;
	assign span      = end_index_q - start_index_q;
	assign count     = {1'b0, span} + CNT_BITS'(1);
	assign divisor   = (playback_mode_q == MODE_LOOP) ? count : {1'b0, span};

	// stall chain
	assign load_s2  = !vld_s2 || div_in_ready;
	assign load_s1  = !vld_s1 || load_s2;
	assign in_ready = load_s1;

	// s1: time x rate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (load_s1) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1 && in_valid) begin
			prod_s1 <= PROD_BITS'(elapsed_time) * PROD_BITS'(frame_rate_q);
		end
	end

	// s2: whole frames and clamped offset
	assign frames_w = prod_s1[PROD_BITS-1 -: FRAME_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (load_s2) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2 && vld_s1) begin
			frames_s2 <= frames_w;
			clamp_s2  <= (frames_w < FRAME_BITS'(span)) ? frames_w[INDEX_BITS-1:0] : span;
		end
	end

	safs_div_pipe u_div (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (vld_s2),
		.in_ready    (div_in_ready),
		.in_frames   (frames_s2),
		.in_clamp    (clamp_s2),
		.divisor     (divisor),
		.out_valid   (div_out_valid),
		.out_ready   (div_out_ready),
		.out_rem     (div_rem),
		.out_lap_odd (div_lap_odd),
		.out_clamp   (div_clamp)
	);

	// output stage
	always_comb begin
		case (playback_mode_q)
			MODE_LOOP: offset = div_rem[INDEX_BITS-1:0];
			MODE_PINGPONG: begin
				if (span == '0) begin
					offset = '0;
				end else if (div_lap_odd) begin
					offset = span - div_rem[INDEX_BITS-1:0];
				end else begin
					offset = div_rem[INDEX_BITS-1:0];
				end
			end
			default: offset = div_clamp;
		endcase
	end

	assign div_out_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (div_out_ready) begin
			out_valid_q <= div_out_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (div_out_ready && div_out_valid) begin
			sprite_index_q <= bad_range ? start_index_q : start_index_q + offset;
			range_error_q  <= bad_range;
		end
	end

	assign out_valid    = out_valid_q;
	assign sprite_index = sprite_index_q;
	assign range_error  = range_error_q;

endmodule

### dv/tb_sprite_anim_frame_select.sv
// ----------------------------------------------------------------------------
// Sprite animation frame select - testbench
// Walks a directed table of register writes and elapsed times, then random
// animation settings and times under three idling patterns. Every result is
// checked field by field, in order, to a table row or an in-bench predictor.
// ----------------------------------------------------------------------------
module tb_sprite_anim_frame_select
	import safs_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [INDEX_BITS-1:0] idx;
		logic                  err;
	} sprite_t;

	typedef enum bit {ROW_CFG, ROW_ITEM} row_kind_t;

	typedef struct packed {
		row_kind_t             kind;
		cfg_reg_t              reg_sel;
		logic [15:0]           data;
		logic [TIME_BITS-1:0]  t_in;
		bit                    typed;
		logic [INDEX_BITS-1:0] exp_idx;
		logic                  exp_err;
	} step_t;

	localparam int N_STEPS = 39;
	localparam int SETS_PER_PHASE = 6;
	localparam int ITEMS_PER_SET = 70;
	localparam int HOLD_CYCLES = 400;

	localparam step_t STEPS [N_STEPS] = '{
		'{ROW_ITEM, REG_START_INDEX,   16'h0000, 32'h0000_0000, 1'b1, 12'd0,    1'b0},
		'{ROW_ITEM, REG_START_INDEX,   16'h0000, 32'hFFFF_FFFF, 1'b1, 12'd0,    1'b0},
		'{ROW_CFG,  REG_START_INDEX,   16'hF00A, 32'h0,         1'b0, 12'd0,    1'b0},
		'{ROW_CFG,  REG_END_INDEX,     16'h0014, 32'h0,         1'b0, 12'd0,    1'b0},
		'{ROW_ITEM, REG_START_INDEX,   16'h0000, 32'h0005_0000, 1'b1, 12'd15,   1'b0},
		'{ROW_ITEM, REG_START_INDEX,   16'h0000, 32'h0000_FFFF, 1'b1, 12'd10,   1'b0},
		'{ROW_ITEM, REG_START_INDEX,   16'h0000, 32'hFFFF_FFFF, 1'b1, 12'd20,   1'b0},
		'{ROW_CFG,  REG_PLAYBACK_MODE, 16'h0001, 32'h0,         1'b0, 12'd0,    1'b0},
		'{ROW_ITEM, REG_START_INDEX,   16'h0000, 32'h000C_0000, 1'b1, 12'd11,   1'b0},
		'{ROW_ITEM, REG_START_INDEX,   16'h0000, 32'hFFFF_FFFF, 1'b0, 12'd0,    1'b0},
		'{ROW_CFG,  REG_PLAYBACK_MODE, 16'h0002, 32'h0,         1'b0, 12'd0,    1'b0},
		'{ROW_ITEM, REG_START_INDEX,   16'h0000, 32'h000F_0000, 1'b0, 12'd0,    1'b0},
		'{ROW_ITEM, REG_START_INDEX,   16'h0000, 32'h0014_0000, 1'b0, 12'd0,    1'b0},
		'{ROW_ITEM, REG_START_INDEX,   16'h0000, 32'h0000_0000, 1'b1, 12'd10,   1'b0},
		'{ROW_CFG,  REG_FRAME_RATE,    16'hFFFF, 32'h0,         1'b0, 12'd0,    1'b0},
		'{ROW_ITEM, REG_START_INDEX,   16'h0000, 32'hFFFF_FFFF, 1'b0, 12'd0,    1'b0},
		'{ROW_ITEM, REG_START_INDEX,   16'h0000, 32'h0000_0001, 1'b0, 12'd0,    1'b0},
		'{ROW_CFG,  REG_PLAYBACK_MODE, 16'hFFFF, 32'h0,         1'b0, 12'd0,    1'b0},
		'{ROW_ITEM, REG_START_INDEX,   16'h0000, 32'hFFFF_FFFF, 1'b1, 12'd20,   1'b0},
		'{ROW_CFG,  REG_FRAME_RATE,    16'h0000, 32'h0,         1'b0, 12'd0,    1'b0},
		'{ROW_ITEM, REG_START_INDEX,   16'h0000, 32'hFFFF_FFFF, 1'b1, 12'd10,   1'b0},
		'{ROW_CFG,  REG_START_INDEX,   16'hFFFF, 32'h0,         1'b0, 12'd0,    1'b0},
		'{ROW_CFG,  REG_END_INDEX,     16'hFFFF, 32'h0,         1'b0, 12'd0,    1'b0},
		'{ROW_CFG,  REG_PLAYBACK_MODE, 16'h0002, 32'h0,         1'b0, 12'd0,    1'b0},
		'{ROW_CFG,  REG_FRAME_RATE,    16'h0100, 32'h0,         1'b0, 12'd0,    1'b0},
		'{ROW_ITEM, REG_START_INDEX,   16'h0000, 32'hFFFF_FFFF, 1'b1, 12'd4095, 1'b0},
		'{ROW_CFG,  REG_START_INDEX,   16'h0064, 32'h0,         1'b0, 12'd0,    1'b0},
		'{ROW_CFG,  REG_END_INDEX,     16'h0032, 32'h0,         1'b0, 12'd0,    1'b0},
		'{ROW_ITEM, REG_START_INDEX,   16'h0000, 32'h1234_5678, 1'b1, 12'd100,  1'b1},
		'{ROW_ITEM, REG_START_INDEX,   16'h0000, 32'h0000_0000, 1'b1, 12'd100,  1'b1},
		'{ROW_CFG,  REG_START_INDEX,   16'h0000, 32'h0,         1'b0, 12'd0,    1'b0},
		'{ROW_CFG,  REG_END_INDEX,     16'h0FFF, 32'h0,         1'b0, 12'd0,    1'b0},
		'{ROW_CFG,  REG_PLAYBACK_MODE, 16'h0001, 32'h0,         1'b0, 12'd0,    1'b0},
		'{ROW_CFG,  REG_FRAME_RATE,    16'hFFFF, 32'h0,         1'b0, 12'd0,    1'b0},
		'{ROW_ITEM, REG_START_INDEX,   16'h0000, 32'hFFFF_FFFF, 1'b0, 12'd0,    1'b0},
		'{ROW_ITEM, REG_START_INDEX,   16'h0000, 32'h8000_0000, 1'b0, 12'd0,    1'b0},
		'{ROW_CFG,  REG_PLAYBACK_MODE, 16'h0002, 32'h0,         1'b0, 12'd0,    1'b0},
		'{ROW_ITEM, REG_START_INDEX,   16'h0000, 32'hFFFF_FFFF, 1'b0, 12'd0,    1'b0},
		'{ROW_ITEM, REG_START_INDEX,   16'h0000, 32'h5555_AAAA, 1'b0, 12'd0,    1'b0}
	};

	logic                     clk;
	logic                     arst_n;
	logic                     cfg_valid;
	logic                     cfg_ready;
	logic [CFG_IDX_BITS-1:0]  cfg_index;
	logic [CFG_DATA_BITS-1:0] cfg_data;
	logic                     in_valid;
	logic                     in_ready;
	logic [TIME_BITS-1:0]     elapsed_time;
	logic                     out_valid;
	logic                     out_ready;
	logic [INDEX_BITS-1:0]    sprite_index;
	logic                     range_error;

	logic [INDEX_BITS-1:0] anim_start;
	logic [INDEX_BITS-1:0] anim_end;
	logic [RATE_BITS-1:0]  anim_rate;
	logic [1:0]            anim_mode;

	sprite_t pending_sprites [$];
	int      errors;
	int      send_idle_pct;
	int      recv_idle_pct;
	bit      rx_hold;

	sprite_anim_frame_select dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.elapsed_time (elapsed_time),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.sprite_index (sprite_index),
		.range_error  (range_error)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	function automatic sprite_t calc_sprite(input logic [TIME_BITS-1:0] t);
		logic [PROD_BITS-1:0]  prod;
		logic [FRAME_BITS-1:0] frames;
		logic [FRAME_BITS-1:0] lap;
		logic [FRAME_BITS-1:0] rem;
		logic [FRAME_BITS-1:0] off;
		logic [FRAME_BITS-1:0] last;
		logic [FRAME_BITS-1:0] span;
		sprite_t               res;
		res.err = 1'b0;
		if (anim_end < anim_start) begin
			res.idx = anim_start;
			res.err = 1'b1;
			return res;
		end
		prod   = PROD_BITS'(t) * PROD_BITS'(anim_rate);
		frames = prod[PROD_BITS-1:FRAC_SHIFT];
		last   = FRAME_BITS'(anim_end) - FRAME_BITS'(anim_start);
		span   = last + 1'b1;
		case (anim_mode)
		MODE_LOOP: begin
			off = frames % span;
		end
		MODE_PINGPONG: begin
			if (last == '0) begin
				off = '0;
			end else begin
				lap = frames / last;
				rem = frames % last;
				off = lap[0] ? last - rem : rem;
			end
		end
		default: begin
			off = (frames < last) ? frames : last;
		end
		endcase
		res.idx = anim_start + off[INDEX_BITS-1:0];
		return res;
	endfunction

	task automatic write_reg(input cfg_reg_t r, input logic [CFG_DATA_BITS-1:0] d);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = r;
		cfg_data  = d;
		do @(posedge clk); while (!cfg_ready);
		case (r)
		REG_START_INDEX:   anim_start = d[INDEX_BITS-1:0];
		REG_END_INDEX:     anim_end   = d[INDEX_BITS-1:0];
		REG_FRAME_RATE:    anim_rate  = d[RATE_BITS-1:0];
		REG_PLAYBACK_MODE: anim_mode  = d[1:0];
		default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Random gaps are taken at the falling edge before the item is offered.
	task automatic send_time(input logic [TIME_BITS-1:0] t, input sprite_t res);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid     = 1'b0;
			elapsed_time = $urandom;
			@(negedge clk);
		end
		in_valid     = 1'b1;
		elapsed_time = t;
		do @(posedge clk); while (!in_ready);
		pending_sprites.push_back(res);
	endtask

	task automatic wait_idle();
		while (pending_sprites.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold) begin
				out_ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				rx_hold = 1'b0;
			end
			out_ready = ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		sprite_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_sprites.size() == 0) begin
				$display("%0t: unexpected result sprite_index %0d range_error %0d",
					$time, sprite_index, range_error);
				errors++;
			end else begin
				want = pending_sprites.pop_front();
				if (sprite_index !== want.idx) begin
					$display("%0t: sprite_index expected %0d got %0d",
						$time, want.idx, sprite_index);
					errors++;
				end
				if (range_error !== want.err) begin
					$display("%0t: range_error expected %0d got %0d",
						$time, want.err, range_error);
					errors++;
				end
			end
		end
	end

	initial begin
		#2_000_000;
		$display("[sprite_anim_frame_select] ERROR");
		$finish;
	end

	initial begin
		step_t                 row;
		logic [TIME_BITS-1:0]  t;
		logic [INDEX_BITS-1:0] s_idx;
		logic [INDEX_BITS-1:0] e_idx;
		logic [RATE_BITS-1:0]  rate;
		longint unsigned       tgt;
		longint unsigned       tt;
		int                    wait_cnt;

		errors        = 0;
		rx_hold       = 1'b0;
		send_idle_pct = 23;
		recv_idle_pct = 54;
		arst_n        = 1'b0;
		cfg_valid     = 1'b0;
		cfg_index     = REG_START_INDEX;
		cfg_data      = '0;
		in_valid      = 1'b0;
		elapsed_time  = '0;
		anim_start    = '0;
		anim_end      = '0;
		anim_rate     = RATE_ONE;
		anim_mode     = MODE_ONCE;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int i = 0; i < N_STEPS; i++) begin
			row = STEPS[i];
			if (row.kind == ROW_CFG) begin
				@(negedge clk);
				in_valid = 1'b0;
				wait_idle();
				write_reg(row.reg_sel, row.data);
			end else if (row.typed) begin
				send_time(row.t_in, '{idx: row.exp_idx, err: row.exp_err});
			end else begin
				send_time(row.t_in, calc_sprite(row.t_in));
			end
		end

		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 23 : (ph == 1) ? 54 : 0;
			recv_idle_pct = (ph == 0) ? 54 : (ph == 1) ? 23 : 0;
			for (int s = 0; s < SETS_PER_PHASE; s++) begin
				@(negedge clk);
				in_valid = 1'b0;
				wait_idle();
				case ($urandom_range(7))
				0: begin
					s_idx = '0;
					e_idx = '1;
				end
				1: begin
					s_idx = INDEX_BITS'($urandom);
					e_idx = s_idx;
				end
				2: begin
					s_idx = INDEX_BITS'($urandom_range(1, 4095));
					e_idx = INDEX_BITS'($urandom_range(0, s_idx - 1));
				end
				3, 4: begin
					s_idx = INDEX_BITS'($urandom);
					e_idx = (s_idx > 4080) ? 12'd4095 :
						INDEX_BITS'(s_idx + $urandom_range(0, 15));
				end
				default: begin
					s_idx = INDEX_BITS'($urandom);
					e_idx = INDEX_BITS'($urandom);
				end
				endcase
				case ($urandom_range(5))
				0:       rate = '0;
				1:       rate = '1;
				2:       rate = RATE_ONE;
				3:       rate = RATE_BITS'($urandom_range(1, 16));
				default: rate = RATE_BITS'($urandom);
				endcase
				write_reg(REG_START_INDEX, {4'($urandom), s_idx});
				write_reg(REG_END_INDEX, {4'($urandom), e_idx});
				write_reg(REG_FRAME_RATE, rate);
				write_reg(REG_PLAYBACK_MODE, {14'($urandom), 2'($urandom_range(3))});
				if (ph == 0 && s == 0)
					rx_hold = 1'b1;
				for (int k = 0; k < ITEMS_PER_SET; k++) begin
					case ($urandom_range(4))
					0: t = $urandom;
					1: t = $urandom_range(0, 32'h00FF_FFFF);
					2: t = $urandom >> $urandom_range(0, 31);
					3: t = 32'hFFFF_FFFF - $urandom_range(0, 255);
					default: begin
						// aim just past a lap or wrap boundary
						tgt = longint'($urandom_range(0, 8)) *
							longint'(anim_end - anim_start) + $urandom_range(0, 2);
						if (anim_rate == '0) begin
							t = $urandom;
						end else begin
							tt = ((tgt << FRAC_SHIFT) + anim_rate - 1) / anim_rate;
							t  = (tt > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : tt[31:0];
						end
					end
					endcase
					send_time(t, calc_sprite(t));
				end
			end
		end

		@(negedge clk);
		in_valid = 1'b0;
		wait_cnt = 0;
		while (pending_sprites.size() != 0 && wait_cnt < 100000) begin
			@(posedge clk);
			wait_cnt++;
		end
		repeat (40) @(posedge clk);
		if (pending_sprites.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, pending_sprites.size());
			errors++;
		end
		if (errors == 0) begin
			$display("[sprite_anim_frame_select] OK");
		end else begin
			$display("[sprite_anim_frame_select] ERROR");
		end
		$finish;
	end

endmodule
